// ----- hdl/json_string_unescape_utf8_assert.svh -----
// Assertion macros shared by the JSON string decoder modules.
// No dependencies; include with the bare file name.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// same-cycle implication, disabled during reset
`define JSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// next-cycle implication, disabled during reset
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

// ----- hdl/jsu_pkg.sv -----
// Types, constants and helper functions for the JSON string decoder.
// No dependencies; used by every module of the block.
package jsu_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    typedef enum logic [3:0] {
        MODE_PLAIN   = 4'd0,
        MODE_ESC     = 4'd1,
        MODE_HEX1    = 4'd2,
        MODE_HEX2    = 4'd3,
        MODE_HEX3    = 4'd4,
        MODE_HEX4    = 4'd5,
        MODE_WANT_BS = 4'd6,
        MODE_WANT_U  = 4'd7,
        MODE_LOW1    = 4'd8,
        MODE_LOW2    = 4'd9,
        MODE_LOW3    = 4'd10,
        MODE_LOW4    = 4'd11
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_CTRL  = 3'd1,
        ERR_ESC   = 3'd2,
        ERR_HEX   = 3'd3,
        ERR_SURR  = 3'd4,
        ERR_QUOTE = 3'd5
    } t_err;

    typedef struct packed {
        logic [7:0]  data;
        t_kind       kind;
        t_err        err;
        logic [15:0] len;
    } t_result;

    typedef struct packed {
        t_result [3:0] res;
        logic [2:0]    cnt;
    } t_group;

    typedef struct packed {
        logic       ok;
        logic [3:0] d;
    } t_hex;

    typedef struct packed {
        logic       ok;
        logic [7:0] data;
    } t_esc;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      cnt;
    } t_enc;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok = 1'b1;
            h.d  = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.ok = 1'b1;
            h.d  = c[3:0] + 4'd9;
        end
        return h;
    endfunction

    function automatic t_esc esc_map(input logic [7:0] c);
        t_esc e;
        e = '{ok: 1'b1, data: c};
        unique case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: e.data = c;
            CH_B: e.data = 8'h08;
            CH_F: e.data = 8'h0C;
            CH_N: e.data = 8'h0A;
            CH_R: e.data = 8'h0D;
            CH_T: e.data = 8'h09;
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic t_enc utf8_encode(input logic [20:0] u);
        t_enc e;
        e = '0;
        if (u <= 21'h7F) begin
            e.cnt  = 3'd1;
            e.b[0] = u[7:0];
        end else if (u <= 21'h7FF) begin
            e.cnt  = 3'd2;
            e.b[0] = {3'b110, u[10:6]};
            e.b[1] = {2'b10, u[5:0]};
        end else if (u <= 21'hFFFF) begin
            e.cnt  = 3'd3;
            e.b[0] = {4'b1110, u[15:12]};
            e.b[1] = {2'b10, u[11:6]};
            e.b[2] = {2'b10, u[5:0]};
        end else begin
            e.cnt  = 3'd4;
            e.b[0] = {5'b11110, u[20:18]};
            e.b[1] = {2'b10, u[17:12]};
            e.b[2] = {2'b10, u[11:6]};
            e.b[3] = {2'b10, u[5:0]};
        end
        return e;
    endfunction

    function automatic t_result data_res(input logic [7:0] b);
        return '{data: b, kind: KIND_DATA, err: ERR_NONE, len: 16'd0};
    endfunction

    function automatic t_group enc_group(input t_enc e);
        t_group g;
        g = '0;
        for (int i = 0; i < 4; i++) begin
            g.res[i] = data_res(e.b[i]);
        end
        g.cnt = e.cnt;
        return g;
    endfunction

    function automatic t_group one_data(input logic [7:0] b);
        t_group g;
        g        = '0;
        g.res[0] = data_res(b);
        g.cnt    = 3'd1;
        return g;
    endfunction

    function automatic t_group one_err(input t_err code);
        t_group g;
        g        = '0;
        g.res[0] = '{data: 8'd0, kind: KIND_ERR, err: code, len: 16'd0};
        g.cnt    = 3'd1;
        return g;
    endfunction

    function automatic t_group one_end(input logic [15:0] len);
        t_group g;
        g        = '0;
        g.res[0] = '{data: 8'd0, kind: KIND_END, err: ERR_NONE, len: len};
        g.cnt    = 3'd1;
        return g;
    endfunction

endpackage

// ----- hdl/json_string_unescape_utf8.sv -----
// JSON string body decoder: escape and surrogate handling with UTF-8 output.
// Top level; depends on jsu_pkg, jsu_decode and jsu_serial.
//
// Input channel: one raw body byte per beat on i_in_byte (i_in_valid,
// o_in_ready), starting after the opening quote; a zero byte marks end of
// buffer. Output channel: one result per beat (o_out_valid, i_out_ready)
// with o_out_byte, o_kind, o_error_code, o_decoded_length and o_last;
// o_last flags the final result produced by an input byte.
// Each accepted byte is decoded in the cycle it is taken and its results
// (none, or one to four) sit in a group register; the first result beat is
// offered the cycle after acceptance. One byte is taken per cycle while each
// byte yields at most one result and the receiver is ready; a byte that
// expands to more than one UTF-8 byte holds the input until its group drains.
// A stalled receiver holds the current result and, once the group register
// is full, stalls the input. Data bytes stream before validity is known: an
// error result tells the receiver to discard the bytes of that string.
// Reset (synchronous, active low) returns the scanner to the plain body with
// a zero length count and empties the result register.
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_decoded_length,
    output logic        o_last
);

    t_group  group;
    t_result result;
    logic    accept;

    assign accept = i_in_valid && o_in_ready;

    jsu_decode #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in_byte(i_in_byte),
        .o_group  (group)
    );

    jsu_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_group     (group),
        .o_load_ready(o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result),
        .o_last      (o_last)
    );

    assign o_out_byte       = result.data;
    assign o_kind           = result.kind;
    assign o_error_code     = result.err;
    assign o_decoded_length = result.len;

endmodule

// ----- hdl/jsu_decode.sv -----
// Scan state and single-pass decode of one body byte into a result group.
// Depends on jsu_pkg and json_string_unescape_utf8_assert.svh.
`include "json_string_unescape_utf8_assert.svh"

module jsu_decode
    import jsu_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    output t_group     o_group
);

    t_mode                  r_mode, n_mode;
    logic [15:0]            r_accum, n_accum;
    logic [9:0]             r_high, n_high;
    logic [LENGTH_BITS-1:0] r_count, n_count;

    t_hex                   hex;
    t_esc                   esc;
    logic [15:0]            acc_new;
    logic                   is_high, is_low;
    t_enc                   enc_bmp, enc_pair;
    logic [15:0]            len_out;
    t_group                 grp;
    logic                   flush;
    logic [2:0]             ndata;
    logic [LENGTH_BITS:0]   sum;

    assign hex      = hex_value(i_in_byte);
    assign esc      = esc_map(i_in_byte);
    assign acc_new  = {r_accum[11:0], hex.d};
    assign is_high  = (acc_new[15:10] == SURR_HIGH_TAG);
    assign is_low   = (acc_new[15:10] == SURR_LOW_TAG);
    assign enc_bmp  = utf8_encode({5'd0, acc_new});
    assign enc_pair = utf8_encode(SUPP_BASE + {1'b0, r_high, acc_new[9:0]});
    assign len_out  = (r_count > LENGTH_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(r_count);

    // result group for this beat
    always_comb begin
        grp   = '0;
        flush = 1'b0;
        unique case (r_mode)
            MODE_ESC: begin
                if (i_in_byte != CH_U) begin
                    if (esc.ok) begin
                        grp = one_data(esc.data);
                    end else begin
                        grp   = one_err(ERR_ESC);
                        flush = 1'b1;
                    end
                end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                if (!hex.ok) begin
                    grp   = one_err(ERR_HEX);
                    flush = 1'b1;
                end
            end
            MODE_HEX4: begin
                if (!hex.ok) begin
                    grp   = one_err(ERR_HEX);
                    flush = 1'b1;
                end else if (!is_high) begin
                    grp = enc_group(enc_bmp);
                end
            end
            MODE_WANT_BS: begin
                if (i_in_byte != CH_BSLASH) begin
                    grp   = one_err(ERR_SURR);
                    flush = 1'b1;
                end
            end
            MODE_WANT_U: begin
                if (i_in_byte != CH_U) begin
                    grp   = one_err(ERR_SURR);
                    flush = 1'b1;
                end
            end
            MODE_LOW1, MODE_LOW2, MODE_LOW3: begin
                if (!hex.ok) begin
                    grp   = one_err(ERR_SURR);
                    flush = 1'b1;
                end
            end
            MODE_LOW4: begin
                if (!hex.ok || !is_low) begin
                    grp   = one_err(ERR_SURR);
                    flush = 1'b1;
                end else begin
                    grp = enc_group(enc_pair);
                end
            end
            default: begin
                priority if (i_in_byte == CH_NUL) begin
                    grp   = one_err(ERR_QUOTE);
                    flush = 1'b1;
                end else if (i_in_byte == CH_QUOTE) begin
                    grp   = one_end(len_out);
                    flush = 1'b1;
                end else if (i_in_byte < CH_SPACE) begin
                    grp   = one_err(ERR_CTRL);
                    flush = 1'b1;
                end else if (i_in_byte == CH_BSLASH) begin
                    grp = '0;
                end else begin
                    grp = one_data(i_in_byte);
                end
            end
        endcase
    end

    assign ndata = flush ? 3'd0 : grp.cnt;
    assign sum   = {1'b0, r_count} + (LENGTH_BITS+1)'(ndata);

    // next scan state
    always_comb begin
        n_mode  = r_mode;
        n_accum = r_accum;
        n_high  = r_high;
        unique case (r_mode)
            MODE_ESC: begin
                n_mode  = (i_in_byte == CH_U) ? MODE_HEX1 : MODE_PLAIN;
                n_accum = '0;
            end
            MODE_HEX1: begin
                n_mode  = MODE_HEX2;
                n_accum = acc_new;
            end
            MODE_HEX2: begin
                n_mode  = MODE_HEX3;
                n_accum = acc_new;
            end
            MODE_HEX3: begin
                n_mode  = MODE_HEX4;
                n_accum = acc_new;
            end
            MODE_HEX4: begin
                n_accum = acc_new;
                if (is_high) begin
                    n_mode = MODE_WANT_BS;
                    n_high = acc_new[9:0];
                end else begin
                    n_mode = MODE_PLAIN;
                end
            end
            MODE_WANT_BS: n_mode = MODE_WANT_U;
            MODE_WANT_U: begin
                n_mode  = MODE_LOW1;
                n_accum = '0;
            end
            MODE_LOW1: begin
                n_mode  = MODE_LOW2;
                n_accum = acc_new;
            end
            MODE_LOW2: begin
                n_mode  = MODE_LOW3;
                n_accum = acc_new;
            end
            MODE_LOW3: begin
                n_mode  = MODE_LOW4;
                n_accum = acc_new;
            end
            MODE_LOW4: begin
                n_mode  = MODE_PLAIN;
                n_accum = acc_new;
            end
            default: n_mode = (i_in_byte == CH_BSLASH) ? MODE_ESC : MODE_PLAIN;
        endcase
        n_count = sum[LENGTH_BITS] ? '1 : sum[LENGTH_BITS-1:0];
        if (flush) begin
            n_mode  = MODE_PLAIN;
            n_accum = '0;
            n_high  = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLAIN;
            r_accum <= '0;
            r_high  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_high  <= n_high;
            r_count <= n_count;
        end
    end

    assign o_group = grp;

    `JSU_ASSERT_NEXT(a_flush_clears_count, i_clk, i_rst_n, i_accept && flush, r_count == '0)
    `JSU_ASSERT_NEXT(a_u_starts_hex, i_clk, i_rst_n,
        i_accept && r_mode == MODE_ESC && i_in_byte == CH_U, r_mode == MODE_HEX1)
    `JSU_ASSERT_IMPL(a_group_bound, i_clk, i_rst_n, i_accept, grp.cnt <= 3'd4)
    `JSU_ASSERT_IMPL(a_flush_single, i_clk, i_rst_n, flush, grp.cnt == 3'd1)

endmodule

// ----- hdl/jsu_serial.sv -----
// Result group register and serialiser: one result beat per cycle while i_out_ready is high.
// Depends on jsu_pkg and json_string_unescape_utf8_assert.svh.
`include "json_string_unescape_utf8_assert.svh"

module jsu_serial
    import jsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_group  i_group,
    output logic    o_load_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result,
    output logic    o_last
);

    t_group     r_group;
    logic       r_full;
    logic [1:0] r_idx;
    logic       take, last, load;

    assign last         = ({1'b0, r_idx} == (r_group.cnt - 3'd1));
    assign take         = r_full && i_out_ready;
    assign o_load_ready = !r_full || (take && last);
    assign load         = i_in_valid && o_load_ready && (i_group.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_full <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last) begin
                r_full <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_group <= i_group;
        end
    end

    assign o_out_valid = r_full;
    assign o_result    = r_group.res[r_idx];
    assign o_last      = last;

    `JSU_ASSERT_IMPL(a_idx_in_group, i_clk, i_rst_n, r_full, {1'b0, r_idx} < r_group.cnt)
    `JSU_ASSERT_NEXT(a_empty_group_skipped, i_clk, i_rst_n,
        !r_full && i_in_valid && i_group.cnt == 3'd0, !r_full)
    `JSU_ASSERT_NEXT(a_idx_advance, i_clk, i_rst_n, take && !last,
        r_full && r_idx == $past(r_idx) + 2'd1)

endmodule

// ----- tb/sv/json_string_unescape_utf8_tb.sv -----
// Self-checking testbench for the JSON string body decoder: random and directed byte streams,
// checked beat by beat against a behavioural decoder kept in this file.
// Depends on jsu_pkg and the json_string_unescape_utf8 top level.
module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LEN_BITS     = LENGTH_BITS_DEF;
    localparam longint CYCLE_LIMIT  = 1000000;
    localparam int     TAIL_CYCLES  = 20;
    localparam int     HOLD_AT      = 200;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     RANDOM_BYTES = 160;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] gap;
        logic       drain;
    } t_raw_byte;

    typedef struct packed {
        logic [7:0]  data;
        t_kind       kind;
        t_err        err;
        logic [15:0] len;
        logic        last;
    } t_decoded;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_kind;
    logic [2:0]  o_error_code;
    logic [15:0] o_decoded_length;
    logic        o_last;

    json_string_unescape_utf8 #(
        .LENGTH_BITS(LEN_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_kind          (o_kind),
        .o_error_code    (o_error_code),
        .o_decoded_length(o_decoded_length),
        .o_last          (o_last)
    );

    t_raw_byte raw_bytes[$];
    t_decoded  decoded_q[$];

    longint n_accepted = 0;
    longint n_predicted = 0;
    longint n_checked = 0;
    longint n_ends = 0;
    longint n_errors = 0;
    longint n_fail = 0;
    longint cycle_cnt = 0;
    int     longest_len = 0;
    int     hold_left = 0;
    bit     hold_done = 1'b0;

    bit     sender_calm = 1'b0;
    bit     drain_next = 1'b0;
    int     gap_left = 0;
    bit     gap_loaded = 1'b0;
    bit     took;
    bit     offer;
    int     rdy_gap = 0;

    t_mode                scan;
    logic [15:0]          acc;
    logic [9:0]           high_bits;
    logic [LEN_BITS-1:0]  byte_cnt;
    t_decoded             grp[4];
    int                   grp_n;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] esc_letter(input int i);
        case (i)
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    // decoder state and result group
    task automatic scan_reset();
        scan      = MODE_PLAIN;
        acc       = '0;
        high_bits = '0;
        byte_cnt  = '0;
    endtask

    task automatic emit(input logic [7:0] d, input t_kind k, input t_err e,
                        input logic [15:0] l);
        grp[grp_n] = '{data: d, kind: k, err: e, len: l, last: 1'b0};
        grp_n++;
    endtask

    task automatic emit_byte(input logic [7:0] d);
        if (byte_cnt != '1) byte_cnt = byte_cnt + 1'b1;
        emit(d, KIND_DATA, ERR_NONE, 16'd0);
    endtask

    task automatic emit_fail(input t_err e);
        scan_reset();
        emit(8'd0, KIND_ERR, e, 16'd0);
    endtask

    task automatic emit_code(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            emit_byte(cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            emit_byte(8'hC0 | cp[10:6]);
            emit_byte(8'h80 | cp[5:0]);
        end else if (cp <= 21'hFFFF) begin
            emit_byte(8'hE0 | cp[15:12]);
            emit_byte(8'h80 | cp[11:6]);
            emit_byte(8'h80 | cp[5:0]);
        end else begin
            emit_byte(8'hF0 | cp[20:18]);
            emit_byte(8'h80 | cp[17:12]);
            emit_byte(8'h80 | cp[11:6]);
            emit_byte(8'h80 | cp[5:0]);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int              d;
        longint unsigned w;
        t_decoded        r;
        grp_n = 0;
        d = hex_nibble(b);
        case (scan)
            MODE_ESC: begin
                scan = MODE_PLAIN;
                case (b)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: emit_byte(b);
                    CH_B: emit_byte(8'h08);
                    CH_F: emit_byte(8'h0C);
                    CH_N: emit_byte(8'h0A);
                    CH_R: emit_byte(8'h0D);
                    CH_T: emit_byte(8'h09);
                    CH_U: begin
                        scan = MODE_HEX1;
                        acc  = '0;
                    end
                    default: emit_fail(ERR_ESC);
                endcase
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
                if (d < 0) begin
                    emit_fail(ERR_HEX);
                end else begin
                    acc = {acc[11:0], 4'(d)};
                    if (scan != MODE_HEX4) begin
                        scan = t_mode'(scan + 1);
                    end else if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                        high_bits = acc[9:0];
                        scan      = MODE_WANT_BS;
                    end else begin
                        scan = MODE_PLAIN;
                        emit_code({5'd0, acc});
                    end
                end
            end
            MODE_WANT_BS: begin
                if (b != CH_BSLASH) emit_fail(ERR_SURR);
                else scan = MODE_WANT_U;
            end
            MODE_WANT_U: begin
                if (b != CH_U) begin
                    emit_fail(ERR_SURR);
                end else begin
                    scan = MODE_LOW1;
                    acc  = '0;
                end
            end
            MODE_LOW1, MODE_LOW2, MODE_LOW3, MODE_LOW4: begin
                if (d < 0) begin
                    emit_fail(ERR_SURR);
                end else begin
                    acc = {acc[11:0], 4'(d)};
                    if (scan != MODE_LOW4) begin
                        scan = t_mode'(scan + 1);
                    end else if (acc < 16'hDC00 || acc > 16'hDFFF) begin
                        emit_fail(ERR_SURR);
                    end else begin
                        scan = MODE_PLAIN;
                        emit_code(21'h10000 + {1'b0, high_bits, acc[9:0]});
                    end
                end
            end
            default: begin
                scan = MODE_PLAIN;
                if (b == CH_NUL) begin
                    emit_fail(ERR_QUOTE);
                end else if (b == CH_QUOTE) begin
                    w = byte_cnt;
                    scan_reset();
                    emit(8'd0, KIND_END, ERR_NONE, (w > 64'hFFFF) ? 16'hFFFF : w[15:0]);
                end else if (b < CH_SPACE) begin
                    emit_fail(ERR_CTRL);
                end else if (b == CH_BSLASH) begin
                    scan = MODE_ESC;
                end else begin
                    emit_byte(b);
                end
            end
        endcase
        for (int i = 0; i < grp_n; i++) begin
            r      = grp[i];
            r.last = (i == grp_n - 1);
            decoded_q.push_back(r);
        end
        n_predicted <= n_predicted + grp_n;
    endtask

    // stimulus builders
    task automatic add(input logic [7:0] b);
        t_raw_byte it;
        it.b     = b;
        it.gap   = sender_calm ? 8'd0 : 8'(pick_gap());
        it.drain = drain_next;
        drain_next = 1'b0;
        raw_bytes.push_back(it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add(s[i]);
    endtask

    task automatic add_hex_digits(input logic [15:0] v, input int n);
        for (int i = 3; i >= 4 - n; i--) add(hex_char(v[i*4 +: 4], 1'($urandom_range(0, 1))));
    endtask

    task automatic add_u(input logic [15:0] v);
        add(CH_BSLASH);
        add(CH_U);
        add_hex_digits(v, 4);
    endtask

    task automatic add_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(32, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
        add(b);
    endtask

    task automatic add_non_hex();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) >= 0);
        add(b);
    endtask

    task automatic add_char();
        int          r;
        logic [15:0] v;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            add_plain();
        end else if (r < 60) begin
            add(CH_BSLASH);
            add(esc_letter($urandom_range(0, 7)));
        end else if (r < 68) begin
            add_u(16'($urandom_range(0, 16'h7F)));
        end else if (r < 76) begin
            add_u(16'($urandom_range(16'h80, 16'h7FF)));
        end else if (r < 86) begin
            do v = 16'($urandom_range(16'h800, 16'hFFFF)); while (v >= 16'hD800 && v <= 16'hDBFF);
            add_u(v);
        end else if (r < 90) begin
            add_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end else begin
            add_u(16'($urandom_range(16'hD800, 16'hDBFF)));
            add_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            scan_reset();
            gap_loaded = 1'b0;
        end else begin
            took = i_in_valid && o_in_ready;
            if (took) begin
                decode_byte(i_in_byte);
                n_accepted <= n_accepted + 1;
            end
            if (!i_in_valid || took) begin
                offer = 1'b0;
                if (raw_bytes.size() != 0) begin
                    if (!gap_loaded) begin
                        gap_left   = raw_bytes[0].gap;
                        gap_loaded = 1'b1;
                    end
                    if (gap_left > 0) begin
                        gap_left--;
                    end else if (!raw_bytes[0].drain || (!took && n_predicted == n_checked)) begin
                        offer      = 1'b1;
                        i_in_byte  <= raw_bytes[0].b;
                        void'(raw_bytes.pop_front());
                        gap_loaded = 1'b0;
                    end
                end
                i_in_valid <= offer;
            end
        end
    end

    // long receiver hold-off once the stream is under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_decoded got;
        t_decoded want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rdy_gap = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{data: o_out_byte, kind: t_kind'(o_kind), err: t_err'(o_error_code),
                        len: o_decoded_length, last: o_last};
                if (got.kind == KIND_END) begin
                    n_ends++;
                    if (int'(got.len) > longest_len) longest_len = int'(got.len);
                end
                if (got.kind == KIND_ERR) n_errors++;
                if (decoded_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected beat byte=%02h kind=%0d err=%0d len=%0d last=%0b",
                             $time, got.data, got.kind, got.err, got.len, got.last);
                end else begin
                    want = decoded_q.pop_front();
                    if (got !== want) begin
                        n_fail++;
                        $display({"%0t: beat %0d expected byte=%02h kind=%0d err=%0d len=%0d",
                                  " last=%0b, got byte=%02h kind=%0d err=%0d len=%0d last=%0b"},
                                 $time, n_checked, want.data, want.kind, want.err, want.len,
                                 want.last, got.data, got.kind, got.err, got.len, got.last);
                    end
                end
                n_checked <= n_checked + 1;
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
            end else if (rdy_gap != 0) begin
                rdy_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (((cycle_cnt / 300) % 4) != 0 && $urandom_range(0, 4) == 0) rdy_gap = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_cnt, n_predicted - n_checked);
            $display("[json_string_unescape_utf8] ERROR");
            $finish;
        end
    end

    initial begin
        int          base_n;
        int          nchar;
        int          k;
        logic [7:0]  b;
        logic [15:0] v;

        // plain extremes, empty string, escapes
        add(CH_QUOTE);
        add(CH_SPACE); add(8'h7F); add(8'h80); add(8'hFF); add(CH_QUOTE);
        add_text("\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
        add_text("\\u007F\\u0080\\u07ff\\u0800\\uFFFF\\uDC00\\uaBcD\"");
        add_text("\\uD800\\uDC00\\udbff\\udfff\"");
        // error paths
        add(8'h1F);
        add(CH_NUL);
        add(CH_BSLASH); add(CH_NUL);
        add_text("\\q");
        add_text("\\u0"); add(CH_NUL);
        add_text("\\uZ");
        add_text("\\uDBFF"); add(CH_NUL);
        add_text("\\uD83Dx");
        add_text("\\uD83D\\x");
        add_text("\\uD83D\\u1"); add(CH_NUL);
        add_text("\\uD83D\\uDz");
        add_text("\\uD800\\uD800");

        // random strings, mostly well formed
        base_n = raw_bytes.size();
        drain_next = 1'b1;
        while (raw_bytes.size() < base_n + RANDOM_BYTES) begin
            if ($urandom_range(0, 7) == 0) drain_next = 1'b1;
            sender_calm = ($urandom_range(0, 5) == 0);
            nchar = $urandom_range(0, 10);
            for (int i = 0; i < nchar; i++) add_char();
            if ($urandom_range(0, 99) < 70) begin
                add(CH_QUOTE);
            end else begin
                case ($urandom_range(0, 7))
                    0: add(8'($urandom_range(1, 31)));
                    1: add(CH_NUL);
                    2: begin
                        add(CH_BSLASH);
                        do b = 8'($urandom_range(0, 255));
                        while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B ||
                               b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U);
                        add(b);
                    end
                    3: begin
                        add(CH_BSLASH);
                        add(CH_U);
                        add_hex_digits(16'($urandom), $urandom_range(0, 3));
                        add_non_hex();
                    end
                    4: begin
                        add_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                        do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
                        add(b);
                    end
                    5: begin
                        add_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                        add(CH_BSLASH);
                        do b = 8'($urandom_range(0, 255)); while (b == CH_U);
                        add(b);
                    end
                    6: begin
                        add_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                        add(CH_BSLASH);
                        add(CH_U);
                        k = $urandom_range(0, 3);
                        add_hex_digits(16'($urandom_range(16'hDC00, 16'hDFFF)), k);
                        add_non_hex();
                    end
                    default: begin
                        add_u(16'($urandom_range(16'hD800, 16'hDBFF)));
                        if ($urandom_range(0, 1) == 0) v = 16'($urandom_range(0, 16'hDBFF));
                        else v = 16'($urandom_range(16'hE000, 16'hFFFF));
                        add_u(v);
                    end
                endcase
            end
        end

        // a short closing string after a full drain
        drain_next  = 1'b1;
        sender_calm = 1'b0;
        add_text("ok\"");

        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (raw_bytes.size() != 0 || i_in_valid) @(posedge i_clk);
        while (n_checked != n_predicted) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("decoded %0d input bytes into %0d result beats in %0d cycles",
                 n_accepted, n_checked, cycle_cnt);
        $display("closed strings %0d (longest length field %0d), error results %0d, mismatches %0d",
                 n_ends, longest_len, n_errors, n_fail);
        if (n_fail == 0 && decoded_q.size() == 0) begin
            $display("[json_string_unescape_utf8] OK");
        end else begin
            $display("[json_string_unescape_utf8] ERROR");
        end
        $finish;
    end

endmodule
